@@ src/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants
// Field types, register indexes, fixed-point constants and the divider
// request and response structs of the attenuation chi-square accumulator.
// ----------------------------------------------------------------------------
package acs_pkg;

  typedef logic [23:0]        u24_t;
  typedef logic signed [23:0] s24_t;

  // Configuration register indexes
  localparam logic [2:0] REG_INTENSITY_SCALE = 3'd0;
  localparam logic [2:0] REG_RESPONSE_SCALE  = 3'd1;
  localparam logic [2:0] REG_ATTEN_SCINT     = 3'd2;
  localparam logic [2:0] REG_ATTEN_VESSEL    = 3'd3;
  localparam logic [2:0] REG_ATTEN_WATER     = 3'd4;

  localparam logic [23:0] SCALE_ONE  = 24'h010000;
  localparam logic [23:0] M24        = 24'hFFFFFF;
  localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
  localparam logic [37:0] PCAP       = {38{1'b1}};
  localparam logic [31:0] TERM_MAX   = 32'hFFFFFFFF;
  localparam logic [39:0] TOTAL_MAX  = {40{1'b1}};
  localparam logic [3:0]  EXP_LAST_K = 4'd13;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // floor(2^32 / k) for the Taylor series steps
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'h80000000;
      4'd3:    r = 32'h55555555;
      4'd4:    r = 32'h40000000;
      4'd5:    r = 32'h33333333;
      4'd6:    r = 32'h2AAAAAAA;
      4'd7:    r = 32'h24924924;
      4'd8:    r = 32'h20000000;
      4'd9:    r = 32'h1C71C71C;
      4'd10:   r = 32'h19999999;
      4'd11:   r = 32'h1745D174;
      4'd12:   r = 32'h15555555;
      4'd13:   r = 32'h13B13B13;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ src/acs_if.sv @@
// ----------------------------------------------------------------------------
// acs_if: item and result channels
// Valid/ready channels carrying one channel item in and one result out.
// ----------------------------------------------------------------------------
interface acs_item_if import acs_pkg::*; ();
  logic valid;
  logic ready;
  u24_t lb_norm_ratio;
  u24_t solid_angle_ratio;
  u24_t fresnel_ratio;
  s24_t dist_scint;
  s24_t dist_vessel;
  s24_t dist_water;
  u24_t occ_ratio;
  u24_t occ_ratio_err;
  logic last_item;

  modport source (
    output valid, lb_norm_ratio, solid_angle_ratio, fresnel_ratio,
           dist_scint, dist_vessel, dist_water, occ_ratio, occ_ratio_err,
           last_item,
    input  ready
  );
  modport sink (
    input  valid, lb_norm_ratio, solid_angle_ratio, fresnel_ratio,
           dist_scint, dist_vessel, dist_water, occ_ratio, occ_ratio_err,
           last_item,
    output ready
  );
endinterface

interface acs_result_if import acs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] chi_term;
  logic [39:0] chi_total;
  logic        end_of_set;
  logic        zero_error;

  modport source (
    output valid, chi_term, chi_total, end_of_set, zero_error,
    input  ready
  );
  modport sink (
    input  valid, chi_term, chi_total, end_of_set, zero_error,
    output ready
  );
endinterface

@@ src/acs_div.sv @@
// ----------------------------------------------------------------------------
// acs_div: restoring divider
// 64 by 48 bit division, one quotient bit per cycle, 32 quotient bits.
// The caller guarantees the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module acs_div import acs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [47:0] rem;
  logic [47:0] den;
  logic [31:0] low;
  logic [31:0] quot;
  logic [48:0] rem2;
  logic [48:0] diff;
  logic        ge;

  assign rem2 = {rem, low[31]};
  assign ge   = rem2 >= {1'b0, den};
  assign diff = rem2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num[63:32];
      low  <= req.num[31:0];
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[47:0] : rem2[47:0];
      low  <= {low[30:0], 1'b0};
      quot <= {quot[30:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ src/attenuation_chi_square_accumulator.sv @@
// ----------------------------------------------------------------------------
// attenuation_chi_square_accumulator: chi-square term and running total
// Forms the attenuated model value of one detector channel, its chi-square
// term against the measured occupancy ratio, and a saturating running sum.
// ----------------------------------------------------------------------------
// Timing: the 12-step exp series on the shared 32x32 multiplier and the
//   32-step divider take most of the time from input transfer to result.
// Flow: one item at a time; a new item is taken once the previous result
//   sits in the output register, which holds it until transfer.
// Reset: synchronous; scales return to 1.0, attenuations and the running
//   total to zero, no result pending.
module attenuation_chi_square_accumulator import acs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  acs_item_if.sink     item,
  acs_result_if.source result,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  // Sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PRE_LO   = 5'd1;
  localparam logic [4:0] S_PRE_HI   = 5'd2;
  localparam logic [4:0] S_PRE_FIN  = 5'd3;
  localparam logic [4:0] S_ATT_MUL  = 5'd4;
  localparam logic [4:0] S_ATT_ACC  = 5'd5;
  localparam logic [4:0] S_RED      = 5'd6;
  localparam logic [4:0] S_NDIV     = 5'd7;
  localparam logic [4:0] S_EXP_INIT = 5'd8;
  localparam logic [4:0] S_EXP_M1   = 5'd9;
  localparam logic [4:0] S_EXP_M2   = 5'd10;
  localparam logic [4:0] S_EXP_M3   = 5'd11;
  localparam logic [4:0] S_EXP_FIX  = 5'd12;
  localparam logic [4:0] S_EXP_END  = 5'd13;
  localparam logic [4:0] S_MOD_LO   = 5'd14;
  localparam logic [4:0] S_MOD_HI   = 5'd15;
  localparam logic [4:0] S_MOD_FIN  = 5'd16;
  localparam logic [4:0] S_TERM_D   = 5'd17;
  localparam logic [4:0] S_TERM_E   = 5'd18;
  localparam logic [4:0] S_TERM_S   = 5'd19;
  localparam logic [4:0] S_DIV_WAIT = 5'd20;
  localparam logic [4:0] S_FINISH   = 5'd21;

  // Configuration registers
  u24_t intensity_scale;
  u24_t response_scale;
  u24_t atten_scint;
  u24_t atten_vessel;
  u24_t atten_water;

  // Captured item
  u24_t c_solid;
  u24_t c_fresnel;
  s24_t c_dist_scint;
  s24_t c_dist_vessel;
  s24_t c_dist_water;
  u24_t c_occ;
  u24_t c_err;
  logic c_last;

  // Datapath registers
  logic [4:0]         state;
  logic [37:0]        p;
  logic [63:0]        lo;
  logic [63:0]        prod;
  logic [1:0]         fi;
  logic [1:0]         ji;
  logic               att_neg;
  logic signed [50:0] s;
  logic               pos;
  logic [37:0]        a;
  logic [6:0]         n;
  logic [2:0]         dk;
  logic [31:0]        q;
  logic [31:0]        term_x;
  logic [31:0]        x;
  logic [31:0]        qe;
  logic [33:0]        sum;
  logic [3:0]         k;
  logic [25:0]        e24;
  logic [23:0]        model;
  logic [63:0]        num;
  logic [31:0]        chi;
  logic               zero;
  logic [39:0]        running_total;

  // Output register
  logic        out_valid;
  logic [31:0] out_term;
  logic [39:0] out_total;
  logic        out_last;
  logic        out_zero;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Shared multiplier operands and per-state helpers
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  u24_t        f_sel;
  s24_t        d_sel;
  u24_t        atten_sel;
  u24_t        d_mag;
  u24_t        resid;
  logic [63:0] full;
  logic [63:0] pre_rnd;
  logic [37:0] pre_sat;
  logic [50:0] s_mag;
  logic [50:0] s_rnd;
  logic [46:0] a47;
  logic [37:0] ln2_step;
  logic [31:0] q_init;
  logic [35:0] fix_rem;
  logic [31:0] fix_t;
  logic [34:0] sum_rnd;
  logic [7:0]  sh;
  logic [63:0] pos_v;
  logic [63:0] neg_sum;
  logic [39:0] neg_v;
  logic [23:0] neg_lim;
  logic [23:0] model_calc;
  logic [40:0] tot_sum;
  logic [39:0] tot_new;
  logic        out_load;

  assign item.ready = (state == S_IDLE);
  assign out_load   = (state == S_FINISH) && (!out_valid || result.ready);

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_scale <= SCALE_ONE;
      response_scale  <= SCALE_ONE;
      atten_scint     <= '0;
      atten_vessel    <= '0;
      atten_water     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTENSITY_SCALE: intensity_scale <= cfg_data;
        REG_RESPONSE_SCALE:  response_scale  <= cfg_data;
        REG_ATTEN_SCINT:     atten_scint     <= cfg_data;
        REG_ATTEN_VESSEL:    atten_vessel    <= cfg_data;
        REG_ATTEN_WATER:     atten_water     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the prefactor chain and the exponent products
  always_comb begin
    case (fi)
      2'd0:    f_sel = c_solid;
      2'd1:    f_sel = c_fresnel;
      2'd2:    f_sel = intensity_scale;
      default: f_sel = response_scale;
    endcase
    case (ji)
      2'd0: begin
        d_sel     = c_dist_scint;
        atten_sel = atten_scint;
      end
      2'd1: begin
        d_sel     = c_dist_vessel;
        atten_sel = atten_vessel;
      end
      default: begin
        d_sel     = c_dist_water;
        atten_sel = atten_water;
      end
    endcase
    d_mag = d_sel[23] ? u24_t'(-d_sel) : u24_t'(d_sel);
    resid = (c_occ >= model) ? (c_occ - model) : (model - c_occ);
  end

  // Shared multiplier: one 32x32 product per cycle, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PRE_LO: begin
        mul_a = p[31:0];
        mul_b = {8'd0, f_sel};
      end
      S_PRE_HI: begin
        mul_a = {26'd0, p[37:32]};
        mul_b = {8'd0, f_sel};
      end
      S_ATT_MUL: begin
        mul_a = {8'd0, d_mag};
        mul_b = {8'd0, atten_sel};
      end
      S_EXP_M1: begin
        mul_a = term_x;
        mul_b = q;
      end
      S_EXP_M2: begin
        mul_a = prod[63:32];
        mul_b = recip(k);
      end
      S_EXP_M3: begin
        mul_a = prod[63:32];
        mul_b = {28'd0, k};
      end
      S_MOD_LO: begin
        mul_a = p[31:0];
        mul_b = {6'd0, e24};
      end
      S_MOD_HI: begin
        mul_a = {26'd0, p[37:32]};
        mul_b = {6'd0, e24};
      end
      S_TERM_D: begin
        mul_a = {8'd0, resid};
        mul_b = {8'd0, resid};
      end
      S_TERM_E: begin
        mul_a = {8'd0, c_err};
        mul_b = {8'd0, c_err};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Arithmetic around the multiplier
  always_comb begin
    full    = lo + {prod[31:0], 32'd0};
    pre_rnd = (full + 64'h8000) >> 16;
    pre_sat = (pre_rnd > {26'd0, PCAP}) ? PCAP : pre_rnd[37:0];

    s_mag = s[50] ? 51'(-s) : 51'(s);
    s_rnd = s_mag + 51'd8;
    a47   = s_rnd[50:4];

    ln2_step = {6'd0, LN2_Q32} << dk;
    q_init   = pos ? (LN2_Q32 - a[31:0]) : a[31:0];

    fix_rem = {4'd0, x} - prod[35:0];
    fix_t   = (fix_rem >= {32'd0, k}) ? (qe + 32'd1) : qe;
    sum_rnd = {1'b0, sum} + 35'd128;

    // Attenuated case: round at 2^(25+n); a shift of 63 or more leaves zero
    sh    = 8'd25 + {1'b0, n};
    pos_v = (full + (64'd1 << (sh - 8'd1))) >> sh;
    // Gain case: round at 2^24, then scale up by 2^n with saturation
    neg_sum = full + 64'h800000;
    neg_v   = neg_sum[63:24];
    neg_lim = M24 >> n;
    if (pos) begin
      if (sh >= 8'd63) begin
        model_calc = '0;
      end else if (pos_v > {40'd0, M24}) begin
        model_calc = M24;
      end else begin
        model_calc = pos_v[23:0];
      end
    end else begin
      if (neg_v > {16'd0, neg_lim}) begin
        model_calc = M24;
      end else begin
        model_calc = neg_v[23:0] << n;
      end
    end

    tot_sum = {1'b0, running_total} + {9'd0, chi};
    tot_new = tot_sum[40] ? TOTAL_MAX : tot_sum[39:0];
  end

  // Divider start with the residual numerator and the squared error
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = num;
    div_req.den   = prod[47:0];
    if (state == S_TERM_S && num[63:32] < prod[47:0]) begin
      div_req.start = 1'b1;
    end
  end

  acs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            state <= S_PRE_LO;
          end
        end
        S_PRE_LO:  state <= S_PRE_HI;
        S_PRE_HI:  state <= S_PRE_FIN;
        S_PRE_FIN: state <= (fi == 2'd3) ? S_ATT_MUL : S_PRE_LO;
        S_ATT_MUL: state <= S_ATT_ACC;
        S_ATT_ACC: state <= (ji == 2'd2) ? S_RED : S_ATT_MUL;
        S_RED: begin
          // Attenuation of 64 or more leaves a zero model
          if (!s[50] && s != '0 && a47 >= 47'(64'd1 << 38)) begin
            state <= S_TERM_D;
          end else begin
            state <= S_NDIV;
          end
        end
        S_NDIV:     state <= (dk == 3'd0) ? S_EXP_INIT : S_NDIV;
        S_EXP_INIT: state <= S_EXP_M1;
        S_EXP_M1:   state <= S_EXP_M2;
        S_EXP_M2:   state <= S_EXP_M3;
        S_EXP_M3:   state <= S_EXP_FIX;
        S_EXP_FIX:  state <= (k == EXP_LAST_K) ? S_EXP_END : S_EXP_M1;
        S_EXP_END:  state <= S_MOD_LO;
        S_MOD_LO:   state <= S_MOD_HI;
        S_MOD_HI:   state <= S_MOD_FIN;
        S_MOD_FIN:  state <= S_TERM_D;
        S_TERM_D:   state <= (c_err == '0) ? S_FINISH : S_TERM_E;
        S_TERM_E:   state <= S_TERM_S;
        S_TERM_S:   state <= div_req.start ? S_DIV_WAIT : S_FINISH;
        S_DIV_WAIT: state <= div_rsp.done ? S_FINISH : S_DIV_WAIT;
        S_FINISH: begin
          if (out_load) begin
            state         <= S_IDLE;
            running_total <= c_last ? '0 : tot_new;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath updates
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        c_solid       <= item.solid_angle_ratio;
        c_fresnel     <= item.fresnel_ratio;
        c_dist_scint  <= item.dist_scint;
        c_dist_vessel <= item.dist_vessel;
        c_dist_water  <= item.dist_water;
        c_occ         <= item.occ_ratio;
        c_err         <= item.occ_ratio_err;
        c_last        <= item.last_item;
        p             <= {14'd0, item.lb_norm_ratio};
        fi            <= '0;
        ji            <= '0;
        s             <= '0;
      end
      S_PRE_HI: lo <= prod;
      S_PRE_FIN: begin
        p  <= pre_sat;
        fi <= fi + 2'd1;
      end
      S_ATT_MUL: att_neg <= d_sel[23];
      S_ATT_ACC: begin
        s  <= att_neg ? (s - $signed({3'd0, prod[47:0]}))
                      : (s + $signed({3'd0, prod[47:0]}));
        ji <= ji + 2'd1;
      end
      S_RED: begin
        pos   <= !s[50] && (s != '0);
        model <= '0;
        n     <= '0;
        dk    <= 3'd6;
        // Clamp large gain at an exponent of 32
        if (s[50] && a47 > 47'(64'd1 << 37)) begin
          a <= 38'(64'd1 << 37);
        end else begin
          a <= a47[37:0];
        end
      end
      S_NDIV: begin
        // Range reduction: one quotient bit of a / ln2 per cycle
        if (a >= ln2_step) begin
          a     <= a - ln2_step;
          n[dk] <= 1'b1;
        end
        dk <= dk - 3'd1;
      end
      S_EXP_INIT: begin
        q      <= q_init;
        term_x <= q_init;
        sum    <= {2'b01, 32'd0} + {2'd0, q_init};
        k      <= 4'd2;
      end
      S_EXP_M2: x  <= prod[63:32];
      S_EXP_M3: qe <= prod[63:32];
      S_EXP_FIX: begin
        term_x <= fix_t;
        sum    <= sum + {2'd0, fix_t};
        k      <= k + 4'd1;
      end
      S_EXP_END: e24 <= sum_rnd[33:8];
      S_MOD_HI:  lo  <= prod;
      S_MOD_FIN: model <= model_calc;
      S_TERM_D: begin
        zero <= (c_err == '0);
        chi  <= TERM_MAX;
      end
      S_TERM_E: num <= {prod[47:0], 16'd0};
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          chi <= div_rsp.quot;
        end
      end
      default: ;
    endcase
  end

  // Result register; hold until transfer
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_term  <= chi;
      out_total <= tot_new;
      out_last  <= c_last;
      out_zero  <= zero;
    end
  end

  assign result.valid      = out_valid;
  assign result.chi_term   = out_term;
  assign result.chi_total  = out_total;
  assign result.end_of_set = out_last;
  assign result.zero_error = out_zero;

  // Checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item taken while a previous item is in work");

  a_zero_saturates: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.zero_error) |-> (result.chi_term == TERM_MAX))
    else $error("zero error without saturated term");

  a_total_covers_term: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.chi_total >= {8'd0, result.chi_term}))
    else $error("running total below its own term");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && c_last) |=> (running_total == '0))
    else $error("running total not cleared after end of set");

endmodule

@@ dv/acs_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_tb_if: testbench view of the item and result channels
// The channel interfaces themselves come from the RTL source list; this file
// only holds the item record the driver queue carries and the result record.
// ----------------------------------------------------------------------------
package acs_tb_pkg;
  import acs_pkg::*;

  typedef struct packed {
    u24_t lb_norm_ratio;
    u24_t solid_angle_ratio;
    u24_t fresnel_ratio;
    s24_t dist_scint;
    s24_t dist_vessel;
    s24_t dist_water;
    u24_t occ_ratio;
    u24_t occ_ratio_err;
    logic last_item;
  } channel_t;

  typedef struct packed {
    logic [31:0] chi_term;
    logic [39:0] chi_total;
    logic        end_of_set;
    logic        zero_error;
  } chi_result_t;
endpackage

@@ dv/attenuation_chi_square_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attenuation_chi_square_accumulator_tb: self-checking bench
// Streams detector channel items through the accumulator, predicts each
// chi-square term and running total in fixed point, and compares every
// result transfer against the oldest prediction, across several register
// settings written while the block is idle.
// ----------------------------------------------------------------------------
module attenuation_chi_square_accumulator_tb;
  import acs_pkg::*;
  import acs_tb_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic [2:0] REG_INDEX_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  acs_item_if   item_ch ();
  acs_result_if result_ch ();

  attenuation_chi_square_accumulator i_dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(result_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: register copies and the running chi-square sum.
  logic [23:0] scale_reg [5];
  logic [39:0] chi_sum;

  channel_t    pending_items [$];
  chi_result_t expected_results [$];
  int  errors = 0;
  longint cycles = 0;
  bit  hold_sender = 1'b0;
  bit  item_took = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_phase = 0;

  function automatic logic [63:0] scale_mul(logic [63:0] p, logic [63:0] f);
    logic [63:0] r;
    r = (p * f + 64'h8000) >> 16;
    return (r > {26'd0, PCAP}) ? {26'd0, PCAP} : r;
  endfunction

  // exp(q) for q in [0, ln2]: Q.32 in, Q.24 out, truncating series through q^13.
  function automatic logic [63:0] exp_series(logic [63:0] q);
    logic [63:0] total, part;
    total = 64'd1 << 32;
    part  = 64'd1 << 32;
    for (int k = 1; k <= 13; k++) begin
      part = ((part * q) >> 32) / k;
      total += part;
    end
    return (total + 64'd128) >> 8;
  endfunction

  function automatic logic [23:0] model_value(channel_t c);
    logic [63:0] p, mag, a, n, r, e24, prod, v, sh, ln2;
    logic signed [63:0] s;
    ln2 = {32'd0, LN2_Q32};
    p = {40'd0, c.lb_norm_ratio};
    p = scale_mul(p, {40'd0, c.solid_angle_ratio});
    p = scale_mul(p, {40'd0, c.fresnel_ratio});
    p = scale_mul(p, {40'd0, scale_reg[REG_INTENSITY_SCALE]});
    p = scale_mul(p, {40'd0, scale_reg[REG_RESPONSE_SCALE]});
    s = 64'(c.dist_scint) * $signed({40'd0, scale_reg[REG_ATTEN_SCINT]})
      + 64'(c.dist_vessel) * $signed({40'd0, scale_reg[REG_ATTEN_VESSEL]})
      + 64'(c.dist_water) * $signed({40'd0, scale_reg[REG_ATTEN_WATER]});
    mag = (s < 0) ? 64'(-s) : 64'(s);
    a = (mag + 64'd8) >> 4;
    if (s > 0) begin
      // attenuation: exp(-x) = 2^-(n+1) * exp(ln2 - r)
      if (a >= (64'd64 << 32)) return 24'd0;
      n = a / ln2;
      r = a - n * ln2;
      e24 = exp_series(ln2 - r);
      prod = p * e24;
      sh = 64'd25 + n;
      if (sh >= 63) return 24'd0;
      v = (prod + (64'd1 << (sh - 1))) >> sh;
    end else begin
      // gain, clamped at x = -32
      if (a > (64'd32 << 32)) a = 64'd32 << 32;
      n = a / ln2;
      r = a - n * ln2;
      e24 = exp_series(r);
      prod = p * e24;
      v = (prod + (64'd1 << 23)) >> 24;
      if (v > (64'hFFFFFF >> n)) return M24;
      v = v << n;
    end
    return (v > 64'hFFFFFF) ? M24 : v[23:0];
  endfunction

  function automatic chi_result_t predict_chi(channel_t c);
    chi_result_t res;
    logic [63:0] model, d, term, e;
    model = {40'd0, model_value(c)};
    res.zero_error = (c.occ_ratio_err == 0);
    if (res.zero_error) begin
      term = {32'd0, TERM_MAX};
    end else begin
      d = (c.occ_ratio >= model) ? c.occ_ratio - model : model - c.occ_ratio;
      e = {40'd0, c.occ_ratio_err};
      term = ((d * d) << 16) / (e * e);
      if (term > 64'hFFFFFFFF) term = {32'd0, TERM_MAX};
    end
    res.chi_term = term[31:0];
    chi_sum = ({24'd0, chi_sum} + term > {24'd0, TOTAL_MAX}) ?
              TOTAL_MAX : chi_sum + term[39:0];
    res.chi_total = chi_sum;
    res.end_of_set = c.last_item;
    if (c.last_item) chi_sum = '0;
    return res;
  endfunction

  // Note an item transfer so the driver advances exactly once per item.
  always @(posedge clk) begin
    item_took <= !rst && item_ch.valid && item_ch.ready;
  end

  // Driver: bursts with random gaps; inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (item_ch.valid && !item_took) begin
      // hold until the transfer
    end else begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        burst_left--;
        item_ch.valid <= 1'b1;
        {item_ch.lb_norm_ratio, item_ch.solid_angle_ratio, item_ch.fresnel_ratio,
         item_ch.dist_scint, item_ch.dist_vessel, item_ch.dist_water,
         item_ch.occ_ratio, item_ch.occ_ratio_err, item_ch.last_item}
          <= pending_items.pop_front();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: long open stretches, then bursty back-pressure.
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (rst) result_ch.ready <= 1'b0;
    else if (stall_phase < 150) result_ch.ready <= 1'b1;
    else result_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // Monitor: predict on item transfer, check on result transfer.
  always @(posedge clk) begin
    chi_result_t got, want;
    channel_t c;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst && item_ch.valid && item_ch.ready) begin
      c = {item_ch.lb_norm_ratio, item_ch.solid_angle_ratio, item_ch.fresnel_ratio,
           item_ch.dist_scint, item_ch.dist_vessel, item_ch.dist_water,
           item_ch.occ_ratio, item_ch.occ_ratio_err, item_ch.last_item};
      expected_results.push_back(predict_chi(c));
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.chi_term, result_ch.chi_total, result_ch.end_of_set,
             result_ch.zero_error};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.chi_term !== want.chi_term || got.chi_total !== want.chi_total ||
            got.end_of_set !== want.end_of_set ||
            got.zero_error !== want.zero_error) begin
          errors++;
          $display("%0t: mismatch term exp %h act %h total exp %h act %h",
                   $time, want.chi_term, got.chi_term, want.chi_total,
                   got.chi_total);
          $display("      end_of_set exp %b act %b zero_error exp %b act %b",
                   want.end_of_set, got.end_of_set, want.zero_error,
                   got.zero_error);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_ATTEN_WATER) scale_reg[idx] = val;
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && expected_results.size() == 0 &&
          !item_ch.valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic channel_t rand_channel(int mode);
    channel_t c;
    c.lb_norm_ratio     = 24'($urandom);
    c.solid_angle_ratio = 24'($urandom);
    c.fresnel_ratio     = 24'($urandom);
    c.dist_scint        = 24'($urandom);
    c.dist_vessel       = 24'($urandom);
    c.dist_water        = 24'($urandom);
    c.occ_ratio         = 24'($urandom);
    c.occ_ratio_err     = 24'($urandom);
    // most items keep ratios near 1.0 and modest distances
    if (mode != 0) begin
      c.lb_norm_ratio     = 24'($urandom_range(32768, 98304));
      c.solid_angle_ratio = 24'($urandom_range(32768, 98304));
      c.fresnel_ratio     = 24'($urandom_range(49152, 81920));
      c.dist_scint        = s24_t'(int'($urandom_range(0, 40960)) - 20480);
      c.dist_vessel       = s24_t'(int'($urandom_range(0, 8192)) - 4096);
      c.dist_water        = s24_t'(int'($urandom_range(0, 40960)) - 20480);
      c.occ_ratio         = 24'($urandom_range(0, 131072));
      c.occ_ratio_err     = $urandom_range(0, 20) == 0 ? 24'd0 :
                            24'($urandom_range(256, 32768));
    end
    c.last_item = ($urandom_range(0, 15) == 0);
    return c;
  endfunction

  task automatic queue_phase(int count);
    for (int i = 0; i < count; i++)
      pending_items.push_back(rand_channel(int'($urandom_range(0, 4))));
  endtask

  initial begin
    channel_t c;
    item_ch.valid = 1'b0;
    item_ch.last_item = 1'b0;
    result_ch.ready = 1'b0;
    scale_reg[0] = SCALE_ONE;
    scale_reg[1] = SCALE_ONE;
    scale_reg[2] = '0;
    scale_reg[3] = '0;
    scale_reg[4] = '0;
    chi_sum = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes at reset settings, zero error with zero residual.
    c = '0;
    pending_items.push_back(c);
    c = '1;
    pending_items.push_back(c);
    c = '0; c.lb_norm_ratio = SCALE_ONE; c.solid_angle_ratio = SCALE_ONE;
    c.fresnel_ratio = SCALE_ONE; c.occ_ratio = SCALE_ONE; c.occ_ratio_err = 24'h000100;
    pending_items.push_back(c);
    c.occ_ratio = 24'h000000; c.occ_ratio_err = 24'h000001;
    pending_items.push_back(c);
    c.last_item = 1'b1;
    pending_items.push_back(c);
    wait_idle();

    // Strong attenuation and gain; overflow the running total.
    write_reg(REG_ATTEN_SCINT, M24);
    write_reg(REG_ATTEN_VESSEL, M24);
    write_reg(REG_ATTEN_WATER, M24);
    write_reg(REG_INDEX_UNUSED, 24'h123456);
    c = '0; c.lb_norm_ratio = SCALE_ONE; c.solid_angle_ratio = SCALE_ONE;
    c.fresnel_ratio = SCALE_ONE; c.occ_ratio_err = 24'h000001;
    c.dist_scint = 24'sh7FFFFF; pending_items.push_back(c);   // x >= 64
    c.dist_scint = 24'sh001000; pending_items.push_back(c);   // x near 1
    c.dist_scint = -24'sh001000; pending_items.push_back(c);
    c.dist_scint = 24'sh800000; pending_items.push_back(c);   // clamp to -32
    c.lb_norm_ratio = '0; pending_items.push_back(c);         // zero model
    c.dist_scint = '0; c.dist_vessel = 24'sh7FFFFF; c.dist_water = 24'sh800000;
    c.lb_norm_ratio = SCALE_ONE; pending_items.push_back(c);
    c.occ_ratio_err = '0;
    for (int i = 0; i < 300; i++) pending_items.push_back(c);  // total saturates
    c.last_item = 1'b1; pending_items.push_back(c);
    wait_idle();

    write_reg(REG_INTENSITY_SCALE, 24'h008000);
    write_reg(REG_RESPONSE_SCALE, 24'h018000);
    write_reg(REG_ATTEN_SCINT, 24'h0A0000);
    write_reg(REG_ATTEN_VESSEL, 24'h400000);
    write_reg(REG_ATTEN_WATER, 24'h003000);
    queue_phase(500);
    // Hold the sender until every expected result has drained.
    wait (pending_items.size() < 250);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    hold_sender = 1'b0;
    wait_idle();

    write_reg(REG_INTENSITY_SCALE, M24);
    write_reg(REG_RESPONSE_SCALE, '0);
    queue_phase(200);
    wait_idle();

    write_reg(REG_INTENSITY_SCALE, 24'($urandom));
    write_reg(REG_RESPONSE_SCALE, 24'($urandom));
    write_reg(REG_ATTEN_SCINT, 24'($urandom));
    write_reg(REG_ATTEN_VESSEL, 24'($urandom));
    write_reg(REG_ATTEN_WATER, 24'($urandom));
    queue_phase(400);
    wait_idle();

    write_reg(REG_INTENSITY_SCALE, SCALE_ONE);
    write_reg(REG_RESPONSE_SCALE, SCALE_ONE);
    write_reg(REG_ATTEN_SCINT, 24'h020000);
    write_reg(REG_ATTEN_VESSEL, '0);
    write_reg(REG_ATTEN_WATER, 24'h008000);
    queue_phase(250);
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
